@@ design/i2c_memory_transaction_sequencer_macros.svh @@
// Assertion helpers shared by the sequencer RTL.
`ifndef I2C_MEMORY_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MEMORY_TRANSACTION_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IMTS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IMTS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/imts_pkg.sv @@
`timescale 1ns / 1ps
package imts_pkg;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // request kinds
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_POLL  = 2'd2;

    // controller flag bits
    localparam logic [4:0] FL_SB   = 5'h01;
    localparam logic [4:0] FL_ADDR = 5'h02;
    localparam logic [4:0] FL_TXE  = 5'h04;
    localparam logic [4:0] FL_BTF  = 5'h08;
    localparam logic [4:0] FL_RXNE = 5'h10;

    // sequencer phases
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_SB1   = 4'd1;
    localparam logic [3:0] PH_ADDR1 = 4'd2;
    localparam logic [3:0] PH_MEM   = 4'd3;
    localparam logic [3:0] PH_WDATA = 4'd4;
    localparam logic [3:0] PH_WBTF  = 4'd5;
    localparam logic [3:0] PH_RTXE  = 4'd6;
    localparam logic [3:0] PH_SB2   = 4'd7;
    localparam logic [3:0] PH_ADDR2 = 4'd8;
    localparam logic [3:0] PH_RDATA = 4'd9;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_START = 2'd1;
    localparam logic [1:0] BUS_STOP  = 2'd2;

    localparam logic [1:0] ACK_KEEP   = 2'd0;
    localparam logic [1:0] ACK_ENABLE = 2'd1;
    localparam logic [1:0] ACK_NACK   = 2'd2;

    localparam logic [1:0] POS_KEEP  = 2'd0;
    localparam logic [1:0] POS_CLEAR = 2'd1;
    localparam logic [1:0] POS_SET   = 2'd2;

    // completion status, timeouts numbered by wait, codes 4 and 5 each shared by two waits
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TO_START    = 4'd1;
    localparam logic [3:0] ST_TO_DEV_ADDR = 4'd2;
    localparam logic [3:0] ST_TO_REG_ADDR = 4'd3;
    localparam logic [3:0] ST_TO_DATA     = 4'd4;
    localparam logic [3:0] ST_TO_WR_END   = 4'd5;
    localparam logic [3:0] ST_TO_RESTART  = 4'd5;
    localparam logic [3:0] ST_TO_RD_ADDR  = 4'd6;
    localparam logic [3:0] ST_TO_RX_LAST  = 4'd7;
    localparam logic [3:0] ST_TO_RX_PAIR  = 4'd8;
    localparam logic [3:0] ST_TO_RX_TRIO  = 4'd9;
    localparam logic [3:0] ST_TO_RX_DATA  = 4'd10;

    // request: last field in the lowest bits
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_second;
        logic [7:0] rx_first;
        logic       tick;
        logic [4:0] status_flags;
        logic [7:0] tx_byte;
        logic [7:0] length;
        logic [7:0] mem_address;
        logic [7:0] dev_address;
    } t_in_item;

    typedef struct packed {
        logic [3:0] status;
        logic       done_res;
        logic [7:0] rx_byte_b;
        logic [7:0] rx_byte_a;
        logic [1:0] rx_count;
        logic       clear_addr;
        logic [1:0] pos_control;
        logic [1:0] ack_next;
        logic       tx_taken;
        logic [7:0] send_byte;
        logic       send_valid;
        logic [1:0] bus_condition;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  phase;
        logic        is_read;
        logic [7:0]  remaining;
        logic [15:0] ticks_left;
        logic [7:0]  saved_device;
        logic [7:0]  saved_register;
    } t_state;

endpackage

@@ design/imts_step.sv @@
`timescale 1ns / 1ps
module imts_step
    import imts_pkg::*;
(
    input  t_state      i_state,
    input  t_in_item    i_item,
    input  logic [15:0] i_timeout,
    output t_state      o_state,
    output t_out_item   o_result
);

    logic [4:0]  want;
    logic [3:0]  code;
    logic        stop_fail;
    logic        active;
    logic [15:0] tl_dec;
    logic [7:0]  rem_dec;
    logic [7:0]  rem_new;

    assign tl_dec  = i_state.ticks_left - 16'd1;
    assign rem_dec = i_state.remaining - 8'd1;

    always_comb begin
        o_state   = i_state;
        o_result  = '0;
        want      = '0;
        code      = ST_OK;
        stop_fail = 1'b0;
        active    = 1'b1;
        rem_new   = i_state.remaining;

        if (i_item.func == FUNC_WRITE || i_item.func == FUNC_READ) begin
            o_state.is_read        = (i_item.func == FUNC_READ);
            o_state.saved_device   = i_item.dev_address;
            o_state.saved_register = i_item.mem_address;
            o_state.remaining      = i_item.length;
            o_state.phase          = PH_SB1;
            o_state.ticks_left     = i_timeout;
            o_result.pos_control   = POS_CLEAR;
            o_result.ack_next      = ACK_ENABLE;
            o_result.bus_condition = BUS_START;
        end else begin
            unique case (i_state.phase)
                PH_SB1:   begin want = FL_SB;   code = ST_TO_START;    end
                PH_ADDR1: begin want = FL_ADDR; code = ST_TO_DEV_ADDR; end
                PH_MEM:   begin want = FL_TXE; code = ST_TO_REG_ADDR; stop_fail = 1'b1; end
                PH_WDATA: begin want = FL_TXE; code = ST_TO_DATA;     stop_fail = 1'b1; end
                PH_WBTF:  begin want = FL_BTF; code = ST_TO_WR_END;   stop_fail = 1'b1; end
                PH_RTXE:  begin want = FL_TXE; code = ST_TO_DATA;     stop_fail = 1'b1; end
                PH_SB2:   begin want = FL_SB;   code = ST_TO_RESTART;  end
                PH_ADDR2: begin want = FL_ADDR; code = ST_TO_RD_ADDR;  end
                PH_RDATA: begin
                    priority if (i_state.remaining == 8'd1) begin
                        want = FL_RXNE; code = ST_TO_RX_LAST;
                    end else if (i_state.remaining == 8'd2) begin
                        want = FL_BTF;  code = ST_TO_RX_PAIR;
                    end else if (i_state.remaining == 8'd3) begin
                        want = FL_BTF;  code = ST_TO_RX_TRIO;
                    end else begin
                        want = FL_RXNE; code = ST_TO_RX_DATA;
                    end
                end
                default: active = 1'b0;
            endcase

            if (!active) begin
                o_state.phase = PH_IDLE;
            end else if ((i_item.status_flags & want) == 5'd0) begin
                // flag not seen yet: spend one tick of the budget when tick is set
                if (i_item.tick) begin
                    o_state.ticks_left = tl_dec;
                    if (tl_dec == 16'd0) begin
                        if (stop_fail) begin
                            o_result.bus_condition = BUS_STOP;
                        end
                        o_result.done_res = 1'b1;
                        o_result.status   = code;
                        o_state.phase     = PH_IDLE;
                    end
                end
            end else begin
                o_state.ticks_left = i_timeout;
                unique case (i_state.phase)
                    PH_SB1: begin
                        o_result.send_valid = 1'b1;
                        o_result.send_byte  = {i_state.saved_device[7:1], 1'b0};
                        o_state.phase       = PH_ADDR1;
                    end
                    PH_ADDR1: begin
                        o_result.clear_addr = 1'b1;
                        o_state.phase       = PH_MEM;
                    end
                    PH_MEM: begin
                        o_result.send_valid = 1'b1;
                        o_result.send_byte  = i_state.saved_register;
                        if (i_state.is_read) begin
                            o_state.phase = PH_RTXE;
                        end else begin
                            o_state.phase = (i_state.remaining != 8'd0) ? PH_WDATA : PH_WBTF;
                        end
                    end
                    PH_WDATA: begin
                        o_result.send_valid = 1'b1;
                        o_result.send_byte  = i_item.tx_byte;
                        o_result.tx_taken   = 1'b1;
                        o_state.remaining   = rem_dec;
                        o_state.phase       = (rem_dec != 8'd0) ? PH_WDATA : PH_WBTF;
                    end
                    PH_WBTF: begin
                        o_result.bus_condition = BUS_STOP;
                        o_result.done_res      = 1'b1;
                        o_result.status        = ST_OK;
                        o_state.phase          = PH_IDLE;
                        o_state.ticks_left     = i_state.ticks_left;
                    end
                    PH_RTXE: begin
                        o_result.bus_condition = BUS_START;
                        o_state.phase          = PH_SB2;
                    end
                    PH_SB2: begin
                        o_result.send_valid = 1'b1;
                        o_result.send_byte  = {i_state.saved_device[7:1], 1'b1};
                        o_state.phase       = PH_ADDR2;
                    end
                    PH_ADDR2: begin
                        o_result.clear_addr = 1'b1;
                        if (i_state.remaining == 8'd0) begin
                            o_result.bus_condition = BUS_STOP;
                            o_result.done_res      = 1'b1;
                            o_state.phase          = PH_IDLE;
                            o_state.ticks_left     = i_state.ticks_left;
                        end else begin
                            if (i_state.remaining == 8'd1) begin
                                o_result.ack_next      = ACK_NACK;
                                o_result.bus_condition = BUS_STOP;
                            end else if (i_state.remaining == 8'd2) begin
                                o_result.ack_next    = ACK_NACK;
                                o_result.pos_control = POS_SET;
                            end
                            o_state.phase = PH_RDATA;
                        end
                    end
                    PH_RDATA: begin
                        o_result.rx_byte_a = i_item.rx_first;
                        priority if (i_state.remaining == 8'd1) begin
                            o_result.rx_count = 2'd1;
                            rem_new           = 8'd0;
                        end else if (i_state.remaining == 8'd2) begin
                            o_result.bus_condition = BUS_STOP;
                            o_result.rx_count      = 2'd2;
                            o_result.rx_byte_b     = i_item.rx_second;
                            rem_new                = 8'd0;
                        end else if (i_state.remaining == 8'd3) begin
                            o_result.ack_next = ACK_NACK;
                            o_result.rx_count = 2'd1;
                            rem_new           = 8'd2;
                        end else if ((i_item.status_flags & FL_BTF) != 5'd0) begin
                            o_result.rx_count  = 2'd2;
                            o_result.rx_byte_b = i_item.rx_second;
                            rem_new            = i_state.remaining - 8'd2;
                        end else begin
                            o_result.rx_count = 2'd1;
                            rem_new           = rem_dec;
                        end
                        o_state.remaining = rem_new;
                        if (rem_new == 8'd0) begin
                            o_result.done_res  = 1'b1;
                            o_state.phase      = PH_IDLE;
                            o_state.ticks_left = i_state.ticks_left;
                        end
                    end
                    default: o_state.phase = PH_IDLE;
                endcase
            end
        end
    end

endmodule

@@ design/i2c_memory_transaction_sequencer.sv @@
`timescale 1ns / 1ps
// Register-addressed I2C transaction sequencer. Send a begin request (tuser = 0 write,
// 1 read) with device address, register address and length; then send one poll request
// (tuser = 2) per controller status sample. Every request yields exactly one result
// carrying the controller commands (start/stop, byte to send, ack/nack, POS, ADDR clear)
// and up to two received bytes; done_res marks the end, status 1..10 names the wait
// that timed out (codes 4 and 5 each name two waits). Each wait allows timeout_ticks
// ticks (0 means 65536). Throughput is one request per clock while the result stream
// is not stalled: a request lands in an input register, one pass of the step logic
// updates the sequencer state and fills the output register, and both stages advance
// together. The output register holds a result under back-pressure while the input
// register still takes the next request. Write timeout_ticks only while the sequencer
// is idle.
module i2c_memory_transaction_sequencer
    import imts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,      // timeout_ticks
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dev_address, mem_address, length, tx_byte, status_flags, tick,
    // rx_first, rx_second, 2 zero pad bits
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,     // func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bus_condition, send_valid, send_byte, tx_taken, ack_next, pos_control,
    // clear_addr, rx_count, rx_byte_a, rx_byte_b, done_res, status
    output logic [39:0] m_axis_tdata
);

`include "i2c_memory_transaction_sequencer_macros.svh"

    logic [15:0] r_timeout;
    t_in_item    r_in;
    logic        r_in_valid;
    t_state      r_state;
    t_out_item   r_out;
    logic        r_out_valid;

    t_state      n_state;
    t_out_item   n_out;
    logic        step_go;
    logic        in_fire;

    // step when a request is held and the result slot is free or draining
    assign step_go       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step_go;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    imts_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_timeout(r_timeout),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= {s_axis_tuser, s_axis_tdata[53:0]};
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, is_read: 1'b0, remaining: 8'd0,
                         ticks_left: 16'd0, saved_device: 8'd0, saved_register: 8'd0};
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    `IMTS_ASSERT_NXT(a_begin_to_sb1, i_clk, i_rst_n,
        step_go && (r_in.func == FUNC_WRITE || r_in.func == FUNC_READ),
        r_state.phase == PH_SB1, "begin request did not enter start wait")
    `IMTS_ASSERT_IMP(a_status_ends, i_clk, i_rst_n,
        r_out_valid && r_out.status != ST_OK, r_out.done_res,
        "timeout status without done")
    `IMTS_ASSERT_IMP(a_send_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.send_valid, r_out.send_byte == 8'd0,
        "send byte set without send valid")
    `IMTS_ASSERT_IMP(a_rx_zero, i_clk, i_rst_n,
        r_out_valid && r_out.rx_count == 2'd0,
        r_out.rx_byte_a == 8'd0 && r_out.rx_byte_b == 8'd0, "rx bytes set without count")
    `IMTS_ASSERT_NXT(a_done_idle, i_clk, i_rst_n,
        step_go && n_out.done_res, r_state.phase == PH_IDLE,
        "sequencer not idle after done")

endmodule
